FILE: rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    // control characters and reset attribute
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_LINEFEED  = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'h07;

    // request kinds carried on tuser
    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // read_row * cols + read_col fits here for any legal column count
    localparam int RD_LIN_W = 13;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic put;      // accept a put transaction
        logic rd;       // accept a read transaction, issue the cell read
        logic rd_load;  // load read data into the output register
        logic clr;      // clear one cell
        logic scr;      // one step of the scroll pass
    } t_dp_cmd;

    typedef struct packed {
        logic will_scroll;
        logic ptr_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/tcw_ram.sv
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wire logic             i_req_type,
    output logic                  o_s_tready,
    input  wire tcw_pkg::t_dp_sts i_sts,
    output tcw_pkg::t_dp_cmd      o_cmd
);

    import tcw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = i_sts.out_free;
                if (i_s_tvalid && i_sts.out_free) begin
                    if (i_req_type == REQ_READ) begin
                        o_cmd.rd = 1'b1;
                        n_state  = ST_READ;
                    end else begin
                        o_cmd.put = 1'b1;
                        if (i_sts.will_scroll) begin
                            n_state = ST_SCROLL;
                        end
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_load = 1'b1;
                n_state       = ST_IDLE;
            end
            ST_SCROLL: begin
                o_cmd.scr = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last scroll write retires this cycle
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/tcw_datapath.sv
`default_nettype none

module tcw_datapath #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire tcw_pkg::t_dp_cmd         i_cmd,
    output tcw_pkg::t_dp_sts              o_sts,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [7:0]               i_cfg_wr_data,
    input  wire logic [7:0]               i_char,
    input  wire logic                     i_eow,
    input  wire logic [4:0]               i_read_row,
    input  wire logic [6:0]               i_read_col,
    input  wire logic                     i_m_tready,
    output logic                          o_m_tvalid,
    output logic [tcw_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic                          o_m_tlast,
    output logic                          o_m_tuser
);

    import tcw_pkg::*;

    localparam int DEPTH  = SCREEN_ROWS * SCREEN_COLS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(SCREEN_COLS);
    localparam int RW     = $clog2(SCREEN_ROWS);
    localparam int COPY_N = (SCREEN_ROWS - 1) * SCREEN_COLS;

    localparam logic [AW-1:0] LAST_BASE = AW'(COPY_N);
    localparam logic [AW-1:0] PTR_LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] COL_LAST  = CW'(SCREEN_COLS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(SCREEN_ROWS - 1);

    // cursor, kept also as a linear cell address
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [AW-1:0] r_lin, n_lin;
    logic          w_scroll;
    logic          w_print;

    logic [7:0]    r_attr;

    // sweep pointer shared by the clear pass and the scroll pass
    logic [AW-1:0] r_ptr;
    logic          w_ptr_last;

    // scroll write lands in the cycle after its read
    logic          r_wr_pend;
    logic [AW-1:0] r_wr_addr;
    logic          r_wr_blank;
    logic          w_copy;

    logic                r_rd_ok;
    logic                w_rd_ok;
    logic [RD_LIN_W-1:0] w_rd_lin;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic [AW-1:0] w_raddr;
    logic [15:0]   w_rdata;

    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic [7:0]    r_out_attr;
    logic [6:0]    r_out_col;
    logic [4:0]    r_out_row;
    logic [10:0]   r_out_lin;
    logic          r_out_move;
    logic          r_out_scr;

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_lin    = r_lin;
        w_scroll = 1'b0;
        w_print  = 1'b0;
        unique case (i_char)
            CH_BACKSPACE: begin
                if (r_col != '0) begin
                    n_col = r_col - CW'(1);
                    n_lin = r_lin - AW'(1);
                end
            end
            CH_RETURN: begin
                n_col = '0;
                n_lin = r_lin - AW'(r_col);
            end
            CH_LINEFEED: begin
                n_col = '0;
                if (r_row == ROW_LAST) begin
                    w_scroll = 1'b1;
                    n_lin    = LAST_BASE;
                end else begin
                    n_row = r_row + RW'(1);
                    n_lin = r_lin - AW'(r_col) + AW'(SCREEN_COLS);
                end
            end
            default: begin
                w_print = 1'b1;
                if (r_col == COL_LAST) begin
                    n_col = '0;
                    if (r_row == ROW_LAST) begin
                        w_scroll = 1'b1;
                        n_lin    = LAST_BASE;
                    end else begin
                        n_row = r_row + RW'(1);
                        n_lin = r_lin + AW'(1);
                    end
                end else begin
                    n_col = r_col + CW'(1);
                    n_lin = r_lin + AW'(1);
                end
            end
        endcase
    end

    assign w_rd_ok  = (int'(i_read_row) < SCREEN_ROWS) && (int'(i_read_col) < SCREEN_COLS);
    assign w_rd_lin = RD_LIN_W'(i_read_row) * RD_LIN_W'(SCREEN_COLS)
                    + RD_LIN_W'(i_read_col);

    assign w_ptr_last = (r_ptr == PTR_LAST);
    assign w_copy     = (r_ptr < LAST_BASE);

    always_comb begin
        if (i_cmd.scr) begin
            w_raddr = w_copy ? r_ptr + AW'(SCREEN_COLS) : '0;
        end else begin
            w_raddr = w_rd_ok ? AW'(w_rd_lin) : '0;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ptr;
        w_wdata = '0;
        if (r_wr_pend) begin
            w_we    = 1'b1;
            w_waddr = r_wr_addr;
            w_wdata = r_wr_blank ? {r_attr, CH_SPACE} : w_rdata;
        end else if (i_cmd.clr) begin
            w_we    = 1'b1;
            w_waddr = r_ptr;
            w_wdata = '0;
        end else if (i_cmd.put && w_print) begin
            w_we    = 1'b1;
            w_waddr = r_lin;
            w_wdata = {r_attr, i_char};
        end
    end

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_lin       <= '0;
            r_attr      <= ATTR_RESET;
            r_ptr       <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
            if (i_cmd.put) begin
                r_col <= n_col;
                r_row <= n_row;
                r_lin <= n_lin;
            end
            if (i_cmd.clr || i_cmd.scr) begin
                r_ptr <= w_ptr_last ? '0 : r_ptr + AW'(1);
            end
            r_wr_pend <= i_cmd.scr;
            if (i_cmd.put || i_cmd.rd_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr  <= r_ptr;
        r_wr_blank <= !w_copy;
        if (i_cmd.rd) begin
            r_rd_ok <= w_rd_ok;
        end
        if (i_cmd.put) begin
            r_out_char <= '0;
            r_out_attr <= '0;
            r_out_col  <= 7'(n_col);
            r_out_row  <= 5'(n_row);
            r_out_lin  <= 11'(n_lin);
            r_out_move <= i_eow;
            r_out_scr  <= w_scroll;
        end else if (i_cmd.rd_load) begin
            r_out_char <= r_rd_ok ? w_rdata[7:0] : 8'h00;
            r_out_attr <= r_rd_ok ? w_rdata[15:8] : 8'h00;
            r_out_col  <= 7'(r_col);
            r_out_row  <= 5'(r_row);
            r_out_lin  <= 11'(r_lin);
            r_out_move <= 1'b0;
            r_out_scr  <= 1'b0;
        end
    end

    assign o_sts.will_scroll = w_scroll;
    assign o_sts.ptr_last    = w_ptr_last;
    assign o_sts.out_free    = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_lin, r_out_row, r_out_col, r_out_attr, r_out_char};
    assign o_m_tlast  = r_out_move;
    assign o_m_tuser  = r_out_scr;

endmodule

`default_nettype wire

FILE: rtl/text_console_writer.sv
// Text console writer: a SCREEN_ROWS x SCREEN_COLS cell memory (attribute in
// bits 15:8, character in 7:0) plus a cursor.
// Slave stream: tuser = request kind (0 put a byte, 1 read a cell), tlast =
// last byte of a write, tdata = char, read row, read col.
// Master stream: one result per request; tdata = cell char/attr (zero on put),
// cursor col/row/linear address after the request; tlast = move cursor (end
// of write on a put); tuser = the put scrolled the screen.
// Config: i_cfg_wr_en/i_cfg_wr_data write the attribute for printed bytes;
// write only while no request is outstanding.
// Timing: a put is taken and its result sits in the output register the
// next cycle, so puts stream at one per cycle while the master side accepts
// and no scroll runs. A read is accepted, then the registered RAM read is
// loaded into the output register; no request is taken in between. A put
// that starts a new line on the last row scrolls: one cell moved per cycle
// through the single write port, input stalled meanwhile. Reset: cursor to
// 0, attribute to 7, then a clear pass zeroes the cells before any request.
// A stalled master side holds its result; a new request is taken only when
// the output register is empty or being drained in that cycle.
`default_nettype none

module text_console_writer #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // tdata: char_byte[7:0], read_row[12:8], read_col[19:13], zero pad
    input  wire logic [tcw_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire logic                         i_s_axis_tlast,
    // tuser: req_type[0]
    input  wire logic                         i_s_axis_tuser,
    // tdata: cell_char[7:0], cell_attr[15:8], cursor_col[22:16],
    //        cursor_row[27:23], cursor_linear[38:28], zero pad
    output logic [tcw_pkg::M_DATA_W-1:0]      o_m_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    output logic                              o_m_axis_tlast,
    // tuser: scrolled[0]
    output logic                              o_m_axis_tuser,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [7:0]                   i_cfg_wr_data
);

    import tcw_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_req_type (i_s_axis_tuser),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tcw_datapath #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_char        (i_s_axis_tdata[7:0]),
        .i_eow         (i_s_axis_tlast),
        .i_read_row    (i_s_axis_tdata[12:8]),
        .i_read_col    (i_s_axis_tdata[19:13]),
        .i_m_tready    (i_m_axis_tready),
        .o_m_tvalid    (o_m_axis_tvalid),
        .o_m_tdata     (o_m_axis_tdata),
        .o_m_tlast     (o_m_axis_tlast),
        .o_m_tuser     (o_m_axis_tuser)
    );

    // no request is taken while a sweep owns the cell memory
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_cmd.clr && !w_cmd.scr)
        else $error("request taken during clear or scroll");

    // read data always lands in the cycle after the read transaction
    a_read_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd |=> w_cmd.rd_load)
        else $error("read transaction not followed by its data load");

    // a read result never overwrites a waiting result
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_load |-> !o_m_axis_tvalid)
        else $error("read result loaded over a pending result");

    // a scrolling put starts the scroll pass right away
    a_scroll_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.put && w_sts.will_scroll) |=> w_cmd.scr)
        else $error("scroll pass did not start after a scrolling put");

endmodule

`default_nettype wire
